@@ src/beac_pkg.sv @@
package beac_pkg;

  // Sizes of the affinity matrix and its values
  localparam int MaxAttr  = 8;
  localparam int IdxW     = 3;
  localparam int CntW     = 4;
  localparam int ValW     = 16;
  localparam int AddrW    = 2 * IdxW;
  localparam int BondW    = 40;
  localparam int ProdW    = 2 * ValW;

  // APB register indexes
  localparam logic REG_ATTR_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POS,
    ST_BOND,
    ST_WAIT,
    ST_EVAL,
    ST_INSERT,
    ST_ROW,
    ST_RD,
    ST_OUT
  } beac_state_t;

  // One read port of the affinity memory
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } rd_port_t;

  // Request to the bond unit
  typedef struct packed {
    logic            start;
    logic [IdxW-1:0] col_a;
    logic [IdxW-1:0] col_b;
    logic [CntW-1:0] rows;
  } bond_req_t;

  // Bond unit status back to the controller
  typedef struct packed {
    logic             done;
    logic [BondW-1:0] bond;
  } bond_rsp_t;

endpackage

@@ src/beac_affinity_ram.sv @@
module beac_affinity_ram
  import beac_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [ValW-1:0]  wdata,
  input  rd_port_t         port_a,
  input  rd_port_t         port_b,
  output logic [ValW-1:0]  rdata_a,
  output logic [ValW-1:0]  rdata_b
);

  logic [ValW-1:0] mem [MaxAttr*MaxAttr];

  // One write port, two registered read ports; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (port_a.en) begin
      rdata_a <= mem[port_a.addr];
    end
    if (port_b.en) begin
      rdata_b <= mem[port_b.addr];
    end
  end

endmodule

@@ src/beac_bond_unit.sv @@
module beac_bond_unit
  import beac_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  bond_req_t       req,
  input  logic [ValW-1:0] rdata_a,
  input  logic [ValW-1:0] rdata_b,
  output rd_port_t        port_a,
  output rd_port_t        port_b,
  output bond_rsp_t       rsp
);

  logic             issuing;
  logic [IdxW-1:0]  row;
  logic [CntW-1:0]  rows;
  logic [IdxW-1:0]  col_a;
  logic [IdxW-1:0]  col_b;
  logic             rd_valid;
  logic             rd_last;
  logic             prod_valid;
  logic             prod_last;
  logic [ProdW-1:0] prod;
  logic [BondW-1:0] acc;
  logic             done;
  logic             issue_last;

  assign issue_last = ({1'b0, row} == rows - CntW'(1));

  // Row reads: column a and column b of the same row
  always_comb begin
    port_a.en   = issuing;
    port_a.addr = {row, col_a};
    port_b.en   = issuing;
    port_b.addr = {row, col_b};
  end

  // Issue rows, then multiply, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      rd_valid   <= issuing;
      prod_valid <= rd_valid;
      done       <= prod_valid && prod_last;
      if (req.start) begin
        issuing <= 1'b1;
      end else if (issuing && issue_last) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      row   <= '0;
      rows  <= req.rows;
      col_a <= req.col_a;
      col_b <= req.col_b;
      acc   <= '0;
    end else begin
      if (issuing) begin
        row <= row + IdxW'(1);
      end
      if (prod_valid) begin
        acc <= acc + BondW'(prod);
      end
    end
    rd_last   <= issue_last;
    prod      <= ProdW'(rdata_a) * ProdW'(rdata_b);
    prod_last <= rd_last;
  end

  assign rsp.done = done;
  assign rsp.bond = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(req.start && issuing))
    else $error("bond start while a bond is in progress");

  a_done_after_issue: assert property (@(posedge clk) disable iff (rst)
    done |-> !issuing)
    else $error("bond done while rows still being issued");

  a_prod_follows_read: assert property (@(posedge clk) disable iff (rst)
    rd_valid |=> prod_valid)
    else $error("product stage lost a row");

  a_issue_feeds_read: assert property (@(posedge clk) disable iff (rst)
    issuing |=> rd_valid)
    else $error("row read not followed by data");

endmodule

@@ src/bond_energy_attribute_clustering_core.sv @@
// Bond energy attribute clustering. Load the N x N affinity matrix one entry
// per transfer on s_t*; the entry with s_tlast set is stored and starts a run.
// During a run s_tready is low. Each attribute k = 2..N-1 is tried at every
// position 0..k; an inner position needs three column bonds, the two end
// positions one each, and each bond streams N rows through the shared
// multiply-accumulate unit at one row per cycle. The N*N results then leave
// on m_t* row by row, each read from the affinity memory and then registered,
// m_tlast on the final one. Every entry read by a run must have been loaded
// before.
module bond_energy_attribute_clustering_core
  import beac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Entry input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // entry_row[2:0], entry_col[5:3], entry_value[21:6]
  input  logic        s_tlast,   // load_last
  // Clustered matrix output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_row[2:0], out_col[5:3], row_attribute[8:6],
                                 // out_value[24:9]
  output logic        m_tlast    // out_last
);

  beac_state_t      state, state_next;
  logic [CntW-1:0]  attribute_count;
  logic [CntW-1:0]  live_n;
  logic [IdxW-1:0]  order [MaxAttr];
  logic [IdxW-1:0]  ord_idx;
  logic [IdxW-1:0]  ord_val;
  logic [CntW-1:0]  k;
  logic [IdxW-1:0]  pos;
  logic [1:0]       sel;
  logic [IdxW-1:0]  left_attr;
  logic [IdxW-1:0]  right_attr;
  logic [BondW-1:0] gain;
  logic [BondW-1:0] loss;
  logic signed [BondW-1:0] contrib;
  logic signed [BondW-1:0] best;
  logic [IdxW-1:0]  best_pos;
  logic [IdxW-1:0]  r;
  logic [IdxW-1:0]  c;
  logic [IdxW-1:0]  row_attr;
  logic             bond_needed;
  logic             pos_last;
  logic             col_last;
  logic             row_last;
  logic             out_free;
  logic             s_xfer;
  logic             cfg_wr;
  bond_req_t        breq;
  bond_rsp_t        brsp;
  rd_port_t         bport_a, bport_b, port_a;
  logic [ValW-1:0]  rdata_a, rdata_b;
  logic [IdxW-1:0]  m_row, m_col, m_attr;
  logic [ValW-1:0]  m_value;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ATTR_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_count <= CntW'(MaxAttr);
    end else if (cfg_wr) begin
      attribute_count <= pwdata[CntW-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ATTR_COUNT: prdata = {{(32-CntW){1'b0}}, attribute_count};
      default:        prdata = '0;
    endcase
  end

  // Clamp the count into the supported range
  always_comb begin
    if (attribute_count < CntW'(2)) begin
      live_n = CntW'(2);
    end else if (attribute_count > CntW'(MaxAttr)) begin
      live_n = CntW'(MaxAttr);
    end else begin
      live_n = attribute_count;
    end
  end

  // Affinity memory and bond unit
  assign s_xfer = s_tvalid && s_tready;

  always_comb begin
    port_a = bport_a;
    if (state == ST_RD) begin
      port_a.en   = 1'b1;
      port_a.addr = {row_attr, ord_val};
    end
  end

  beac_affinity_ram u_ram (
    .clk     (clk),
    .we      (s_xfer),
    .waddr   ({s_tdata[2:0], s_tdata[5:3]}),
    .wdata   (s_tdata[21:6]),
    .port_a  (port_a),
    .port_b  (bport_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  beac_bond_unit u_bond (
    .clk     (clk),
    .rst     (rst),
    .req     (breq),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .port_a  (bport_a),
    .port_b  (bport_b),
    .rsp     (brsp)
  );

  // Order lookup, one index per cycle
  always_comb begin
    case (state)
      ST_ROW:  ord_idx = r;
      ST_POS:  ord_idx = pos;
      default: ord_idx = c;
    endcase
  end
  assign ord_val = order[ord_idx];

  // Position and emission bookkeeping
  always_comb begin
    case (sel)
      2'd0:    bond_needed = (pos != '0);
      2'd1:    bond_needed = ({1'b0, pos} != k);
      2'd2:    bond_needed = (pos != '0) && ({1'b0, pos} != k);
      default: bond_needed = 1'b0;
    endcase
  end
  assign pos_last = ({1'b0, pos} == k);
  assign col_last = ({1'b0, c} == live_n - CntW'(1));
  assign row_last = ({1'b0, r} == live_n - CntW'(1));
  assign out_free = !m_tvalid || m_tready;
  assign contrib  = $signed((gain - loss) << 1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (s_xfer && s_tlast) state_next = ST_INIT;
      ST_INIT:   state_next = (live_n == CntW'(2)) ? ST_ROW : ST_POS;
      ST_POS:    state_next = ST_BOND;
      ST_BOND: begin
        if (sel == 2'd3) begin
          state_next = ST_EVAL;
        end else if (bond_needed) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT:   if (brsp.done) state_next = ST_BOND;
      ST_EVAL:   state_next = pos_last ? ST_INSERT : ST_POS;
      ST_INSERT: state_next = (k + CntW'(1) == live_n) ? ST_ROW : ST_POS;
      ST_ROW:    state_next = ST_RD;
      ST_RD:     state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          if (col_last && row_last) begin
            state_next = ST_LOAD;
          end else if (col_last) begin
            state_next = ST_ROW;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      default:   state_next = ST_LOAD;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    s_tready   = (state == ST_LOAD);
    breq.start = (state == ST_BOND) && (sel != 2'd3) && bond_needed;
    breq.rows  = live_n;
    case (sel)
      2'd0:    begin breq.col_a = left_attr; breq.col_b = k[IdxW-1:0]; end
      2'd1:    begin breq.col_a = k[IdxW-1:0]; breq.col_b = right_attr; end
      default: begin breq.col_a = left_attr; breq.col_b = right_attr; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Placement datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_INIT: begin
        for (int j = 0; j < MaxAttr; j++) begin
          order[j] <= IdxW'(j);
        end
        k        <= CntW'(2);
        pos      <= '0;
        best     <= '1;
        best_pos <= '0;
        r        <= '0;
      end
      ST_POS: begin
        right_attr <= ord_val;
        sel        <= 2'd0;
        gain       <= '0;
        loss       <= '0;
      end
      ST_BOND: begin
        if (sel != 2'd3 && !bond_needed) begin
          sel <= sel + 2'd1;
        end
      end
      ST_WAIT: begin
        if (brsp.done) begin
          if (sel == 2'd2) begin
            loss <= brsp.bond;
          end else begin
            gain <= gain + brsp.bond;
          end
          sel <= sel + 2'd1;
        end
      end
      ST_EVAL: begin
        if (contrib > best) begin
          best     <= contrib;
          best_pos <= pos;
        end
        left_attr <= right_attr;
        if (!pos_last) begin
          pos <= pos + IdxW'(1);
        end
      end
      ST_INSERT: begin
        for (int j = 0; j < MaxAttr; j++) begin
          if (IdxW'(j) == best_pos) begin
            order[j] <= k[IdxW-1:0];
          end else if (IdxW'(j) > best_pos && CntW'(j) <= k && j > 0) begin
            order[j] <= order[(j > 0) ? j - 1 : 0];
          end
        end
        k        <= k + CntW'(1);
        pos      <= '0;
        best     <= '1;
        best_pos <= '0;
        r        <= '0;
      end
      ST_ROW: begin
        row_attr <= ord_val;
        c        <= '0;
      end
      ST_OUT: begin
        if (out_free) begin
          if (col_last) begin
            r <= r + IdxW'(1);
          end else begin
            c <= c + IdxW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_row   <= r;
      m_col   <= c;
      m_attr  <= row_attr;
      m_value <= rdata_a;
      m_tlast <= col_last && row_last;
    end
  end

  assign m_tdata = {7'b0, m_value, m_attr, m_col, m_row};

  a_bond_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    brsp.done |-> state == ST_WAIT)
    else $error("bond result arrived outside the wait state");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> {1'b0, pos} <= k)
    else $error("position beyond the attribute being placed");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_INSERT |-> {1'b0, best_pos} <= k)
    else $error("insert position beyond the attribute being placed");

  a_last_is_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_row == m_col)
    else $error("final result not on the matrix corner");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import beac_pkg::*;

  // One entry of the clustered matrix as it should leave the block
  typedef struct {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] attr;
    logic [ValW-1:0] value;
    logic            last;
  } clustered_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // entry_row[2:0], entry_col[5:3], entry_value[21:6]
  logic        s_tlast = 1'b0; // load_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // out_row[2:0], out_col[5:3], row_attribute[8:6],
                               // out_value[24:9]
  logic        m_tlast;        // out_last

  // Mirror of the block: affinity matrix, count register, attribute order
  logic [ValW-1:0] affinity [MaxAttr][MaxAttr];
  logic [CntW-1:0] attr_count_reg;
  int              attr_order [MaxAttr];
  clustered_t      clustered_q [$];

  int  error_count;
  int  entries_sent;
  int  runs_started;
  int  results_seen;
  bit  calm;

  bond_energy_attribute_clustering_core DUT (.*);

  always #6 clk = ~clk;

  // Sum over the live rows of the product of two attribute columns
  function automatic longint column_bond(int a, int b, int n);
    longint sum;
    sum = 0;
    for (int z = 0; z < n; z++) sum += longint'(affinity[z][a]) * longint'(affinity[z][b]);
    return sum;
  endfunction

  // Bond energy ordering, then queue the reordered matrix
  task automatic predict_clustering();
    int n;
    longint best, gain, loss, contrib;
    int best_pos;
    clustered_t ent;
    n = attr_count_reg;
    if (n < 2) n = 2;
    if (n > MaxAttr) n = MaxAttr;
    for (int i = 0; i < MaxAttr; i++) attr_order[i] = i;
    for (int k = 2; k < n; k++) begin
      best = -1;
      best_pos = 0;
      for (int i = 0; i <= k; i++) begin
        gain = 0;
        loss = 0;
        if (i > 0) gain += column_bond(attr_order[i-1], k, n);
        if (i < k) gain += column_bond(k, attr_order[i], n);
        if (i > 0 && i < k) loss = column_bond(attr_order[i-1], attr_order[i], n);
        contrib = (gain - loss) * 2;
        if (contrib > best) begin
          best = contrib;
          best_pos = i;
        end
      end
      for (int j = k; j > best_pos; j--) attr_order[j] = attr_order[j-1];
      attr_order[best_pos] = k;
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        ent.row   = r[IdxW-1:0];
        ent.col   = c[IdxW-1:0];
        ent.attr  = attr_order[r][IdxW-1:0];
        ent.value = affinity[attr_order[r]][attr_order[c]];
        ent.last  = (r == n - 1 && c == n - 1);
        clustered_q.insert(clustered_q.size(), ent);
      end
    end
    runs_started++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Register write: setup cycle, then access cycle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == 3'(4 * REG_ATTR_COUNT)) attr_count_reg = data[CntW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send one matrix entry; tvalid is left high for the caller to lower
  task automatic send_entry(input int row, input int col, input int value, input bit last);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, value[ValW-1:0], col[IdxW-1:0], row[IdxW-1:0]};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    affinity[row[IdxW-1:0]][col[IdxW-1:0]] = value[ValW-1:0];
    entries_sent++;
    if (last) predict_clustering();
  endtask

  // Let every result of the current run out, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (clustered_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Load all n x n entries with a value source, the final one starting a run
  task automatic load_square(input int n, input int mode);
    int v;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        case (mode)
          0: v = 0;
          1: v = 16'hFFFF;
          2: v = 7;
          default: v = $urandom_range(16'hFFFF);
        endcase
        send_entry(r, c, v, r == n - 1 && c == n - 1);
      end
    end
  endtask

  // Random affinity with a bias toward the extremes and small values
  function automatic int random_value();
    case ($urandom_range(5))
      0: return 0;
      1: return 16'hFFFF;
      2: return $urandom_range(15);
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  // Reset default count, full matrix so no later run reads an unloaded entry
  task automatic test_full_load();
    load_square(MaxAttr, 3);
    drain();
  endtask

  // Smallest matrix with extreme values, counts below the minimum
  task automatic test_small_counts();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd2);
    send_entry(0, 0, 16'hFFFF, 1'b0);
    send_entry(0, 1, 0, 1'b0);
    send_entry(1, 0, 1, 1'b0);
    send_entry(1, 1, 16'hFFFF, 1'b1);
    drain();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd0);
    send_entry(1, 0, 16'hFFFF, 1'b1);
    drain();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd1);
    send_entry(0, 1, 16'h8000, 1'b1);
    drain();
  endtask

  // All-zero and all-equal matrices: every position ties, the first one wins
  task automatic test_ties();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd3);
    load_square(3, 0);
    drain();
    load_square(3, 2);
    drain();
  endtask

  // Counts above the maximum clamp to the full matrix; entry at the top corner
  task automatic test_large_counts();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd15);
    send_entry(7, 7, 16'hFFFF, 1'b1);
    drain();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd9);
    send_entry(7, 0, 0, 1'b1);
    drain();
    apb_write(3'(4 * REG_ATTR_COUNT), 32'd8);
    send_entry(3, 5, 16'hA5A5, 1'b1);
    drain();
  endtask

  // Random runs: at times a new count, then entries, the last starting the run
  task automatic test_random_runs();
    int budget, burst, n;
    budget = 0;
    while (budget < 360) begin
      calm = (budget > 200 && budget < 270);
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(15);
        apb_write(3'(4 * REG_ATTR_COUNT), n);
      end
      n = $urandom_range(3) == 0 ? 8 : $urandom_range(2, 5);
      if ($urandom_range(7) == 0) begin
        apb_write(3'(4 * REG_ATTR_COUNT), n);
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++)
            send_entry(r, c, random_value(), r == n - 1 && c == n - 1);
        budget += n * n;
      end else begin
        burst = $urandom_range(1, 20);
        for (int i = 0; i < burst; i++)
          send_entry($urandom_range(7), $urandom_range(7), random_value(), i == burst - 1);
        budget += burst;
      end
      drain();
    end
    calm = 1'b0;
  endtask

  // Output back-pressure, with one stall-free stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(99) >= 38;
    end
  end

  // Compare each result transfer with the oldest expected entry
  always @(posedge clk) begin
    clustered_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (clustered_q.size() == 0) begin
        report_mismatch("unexpected result, out_row", m_tdata[2:0], -1);
      end else begin
        want = clustered_q.pop_front();
        if (m_tdata[2:0] != want.row) report_mismatch("out_row", m_tdata[2:0], want.row);
        if (m_tdata[5:3] != want.col) report_mismatch("out_col", m_tdata[5:3], want.col);
        if (m_tdata[8:6] != want.attr)
          report_mismatch("row_attribute", m_tdata[8:6], want.attr);
        if (m_tdata[24:9] != want.value)
          report_mismatch("out_value", m_tdata[24:9], want.value);
        if (m_tlast != want.last) report_mismatch("out_last", m_tlast, want.last);
      end
    end
  end

  initial begin
    error_count = 0;
    entries_sent = 0;
    runs_started = 0;
    results_seen = 0;
    calm = 1'b0;
    attr_count_reg = 4'd8;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_load();
    test_small_counts();
    test_ties();
    test_large_counts();
    test_random_runs();
    drain();
    repeat (40) @(posedge clk);
    if (clustered_q.size() != 0)
      report_mismatch("results still outstanding", 0, clustered_q.size());
    $display("Loaded %0d entries, %0d clustering runs, %0d result transfers checked",
             entries_sent, runs_started, results_seen);
    $display("Counts 0..15 including clamped values, tie and zero matrices, random stalls");
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("Timeout: %0d results still outstanding", clustered_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
